FILE: rtl/ahcfr_pkg.sv
// ----------------------------------------------------------------------------
// ahcfr_pkg
// Shared types, constants and helpers for the hex checksum frame receiver.
// ----------------------------------------------------------------------------
package ahcfr_pkg;

  localparam int unsigned MaxFrameDef = 256;
  localparam int unsigned CmdChars    = 3;
  localparam int unsigned CksumChars  = 2;
  localparam int unsigned TermChars   = 2;
  localparam int unsigned HoldDepth   = 4;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [4:0] NotHex = 5'd16;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CKSUM_ERR = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [11:0] command;
    logic [7:0]  data_length;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = NotHex;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    return d;
  endfunction

endpackage

FILE: rtl/ascii_hex_checksum_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// ascii_hex_checksum_frame_receiver_core
// CR LF terminated frame receiver with an ASCII hex 8-bit sum checksum.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one received byte per item in tdata[7:0]
//   m_axis: one result per item; tuser is the kind (data byte or frame end),
//   tlast marks the last result caused by one received byte
//   an accepted byte is registered in the input register, processed there and
//   its results are written into the result queue, which m_axis reads
//   one byte per cycle is taken while the queue has two free entries; a byte
//   that causes a payload byte and a frame end gives two results on m_axis
//   results wait in a four-entry queue; a held byte is not processed and
//   s_axis tready drops while fewer than two queue entries are free, so a
//   stalled m_axis holds back input and no result is lost
//   reset empties the queue and clears the delay line, sum and command parse
//   after every frame end result the frame state returns to its reset value
// ----------------------------------------------------------------------------
module ascii_hex_checksum_frame_receiver_core #(
  parameter int unsigned MaxFrame = ahcfr_pkg::MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // data_byte, command, data_length, status, zero pad
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);

  ahcfr_pkg::push_t   push;
  ahcfr_pkg::result_t res;
  logic               space_ok;

  ahcfr_parse #(
    .MaxFrame(MaxFrame)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  ahcfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {2'b00, res.status, res.data_length, res.command, res.data_byte};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

FILE: rtl/ahcfr_parse.sv
// ----------------------------------------------------------------------------
// ahcfr_parse
// Input register, delay line, running sum, command parse and frame end logic.
// ----------------------------------------------------------------------------
module ahcfr_parse #(
  parameter int unsigned MaxFrame = ahcfr_pkg::MaxFrameDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               space_ok_i,
  output ahcfr_pkg::push_t   push_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 2);
  localparam int unsigned MinFrame =
    ahcfr_pkg::CmdChars + ahcfr_pkg::CksumChars + ahcfr_pkg::TermChars;
  localparam int unsigned FirstPayload = ahcfr_pkg::HoldDepth + ahcfr_pkg::CmdChars;

  logic            in_valid_q;
  logic [7:0]      byte_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      hold_q [ahcfr_pkg::HoldDepth];
  logic [7:0]      hold_d [ahcfr_pkg::HoldDepth];
  logic [11:0]     cmd_q, cmd_d;
  logic            stop_q, stop_d;

  logic            advance;
  logic            leave;
  logic [7:0]      leaving;
  logic [4:0]      lead_dig;
  logic            pay_vld;
  logic [CntW-1:0] cnt1;
  logic            term;
  logic            summ;
  ahcfr_pkg::status_e st;
  logic [7:0]      len;
  logic [4:0]      d0, d1;
  logic [7:0]      ck;
  ahcfr_pkg::result_t pay_r, end_r;

  assign advance    = in_valid_q && space_ok_i;
  assign in_ready_o = !in_valid_q || space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  always_comb begin
    leave    = cnt_q >= CntW'(ahcfr_pkg::HoldDepth);
    leaving  = hold_q[0];
    lead_dig = ahcfr_pkg::hex_digit(leaving);
    sum_d    = leave ? 8'(sum_q + leaving) : sum_q;
    cmd_d    = cmd_q;
    stop_d   = stop_q;
    pay_vld  = 1'b0;
    if (leave && cnt_q < CntW'(FirstPayload)) begin
      if (!stop_q && lead_dig != ahcfr_pkg::NotHex) begin
        cmd_d = {cmd_q[7:0], lead_dig[3:0]};
      end else begin
        stop_d = 1'b1;
      end
    end else if (leave) begin
      pay_vld = 1'b1;
    end

    for (int i = 0; i < ahcfr_pkg::HoldDepth - 1; i++) begin
      hold_d[i] = hold_q[i+1];
    end
    hold_d[ahcfr_pkg::HoldDepth-1] = byte_q;
    cnt1 = cnt_q + CntW'(1);

    term = cnt1 >= CntW'(ahcfr_pkg::TermChars) && hold_d[2] == ahcfr_pkg::ChCr &&
           hold_d[3] == ahcfr_pkg::ChLf;
    d0 = ahcfr_pkg::hex_digit(hold_d[0]);
    d1 = ahcfr_pkg::hex_digit(hold_d[1]);
    if (d0 == ahcfr_pkg::NotHex) ck = 8'd0;
    else if (d1 == ahcfr_pkg::NotHex) ck = {4'd0, d0[3:0]};
    else ck = {d0[3:0], d1[3:0]};

    summ = 1'b0;
    st   = ahcfr_pkg::ST_OK;
    len  = 8'd0;
    if (term) begin
      summ = 1'b1;
      if (cnt1 < CntW'(MinFrame)) begin
        st = ahcfr_pkg::ST_TOO_SHORT;
      end else begin
        len = 8'(cnt1 - CntW'(MinFrame));
        st  = (ck == sum_d) ? ahcfr_pkg::ST_OK : ahcfr_pkg::ST_CKSUM_ERR;
      end
    end else if (cnt1 > CntW'(MaxFrame)) begin
      summ = 1'b1;
      st   = ahcfr_pkg::ST_TOO_LONG;
      if (cnt1 > CntW'(FirstPayload)) len = 8'(cnt1 - CntW'(FirstPayload));
    end

    pay_r             = '0;
    pay_r.kind        = ahcfr_pkg::KIND_DATA;
    pay_r.data_byte   = leaving;
    pay_r.last        = !summ;
    end_r             = '0;
    end_r.kind        = ahcfr_pkg::KIND_END;
    end_r.command     = cmd_d;
    end_r.data_length = len;
    end_r.status      = st;
    end_r.last        = 1'b1;

    push_o = '0;
    if (advance) begin
      unique case ({pay_vld, summ})
        2'b11: begin
          push_o.cnt = 2'd2;
          push_o.r0  = pay_r;
          push_o.r1  = end_r;
        end
        2'b10: begin
          push_o.cnt = 2'd1;
          push_o.r0  = pay_r;
        end
        2'b01: begin
          push_o.cnt = 2'd1;
          push_o.r0  = end_r;
        end
        default: begin
          push_o.cnt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      cmd_q  <= '0;
      stop_q <= 1'b0;
      for (int i = 0; i < ahcfr_pkg::HoldDepth; i++) hold_q[i] <= '0;
    end else if (advance) begin
      if (summ) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        cmd_q  <= '0;
        stop_q <= 1'b0;
        for (int i = 0; i < ahcfr_pkg::HoldDepth; i++) hold_q[i] <= '0;
      end else begin
        cnt_q  <= cnt1;
        sum_q  <= sum_d;
        cmd_q  <= cmd_d;
        stop_q <= stop_d;
        for (int i = 0; i < ahcfr_pkg::HoldDepth; i++) hold_q[i] <= hold_d[i];
      end
    end
  end

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && summ) |=> (cnt_q == '0 && sum_q == 8'd0 && !stop_q))
    else $error("frame state not cleared after summary");

  a_two_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |->
      (push_o.r0.kind == ahcfr_pkg::KIND_DATA && !push_o.r0.last && push_o.r1.last))
    else $error("payload and summary pushed in wrong order");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxFrame))
    else $error("byte count beyond maximum frame");

endmodule

FILE: rtl/ahcfr_queue.sv
// ----------------------------------------------------------------------------
// ahcfr_queue
// Result queue taking up to two results per cycle and sending one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module ahcfr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ahcfr_pkg::push_t   push_i,
  output logic               space_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ahcfr_pkg::result_t out_res_o
);

  localparam int unsigned PtrW = $clog2(ahcfr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(ahcfr_pkg::QueueDepth + 1);

  ahcfr_pkg::result_t mem_q [ahcfr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;
  logic [PtrW-1:0] wr_ptr1;

  assign space_ok_o  = count_q <= CntW'(ahcfr_pkg::QueueDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr1     = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ahcfr_pkg::QueueDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> space_ok_o)
    else $error("push without room");

endmodule
